FILE: src/i2a_pkg.sv
// shared constants, types and helpers for the integer to radix ascii block
package i2a_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int MAX_RADIX_DEFAULT = 36;
    localparam int DEFAULT_RADIX     = 10;
    localparam int STEP_BITS         = 8;
    localparam int RADIX_W           = 6;
    localparam int CHAR_W            = 7;
    localparam int LEN_W             = 6;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIVIDE,
        B_EMIT
    } back_state_t;

    // digit value to ascii, letters are lower case
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < RADIX_W'(10))
            return CHAR_ZERO + dx;
        else
            return CHAR_LOWER_A + dx - CHAR_W'(10);
    endfunction

endpackage

FILE: src/i2a_ram.sv
// generic single write port, single read port ram with registered read
module i2a_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/i2a_queue.sv
// two entry word queue between the front and the back
module i2a_queue #(
    parameter int WIDTH = 39
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd_en,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = $clog2(i2a_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(i2a_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [i2a_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(i2a_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(i2a_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(i2a_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/i2a_front.sv
// front end: radix register, sign split and magnitude, base resolution
module i2a_front #(
    parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEFAULT,
    parameter int MAX_RADIX = i2a_pkg::MAX_RADIX_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_we,
    input  logic [i2a_pkg::RADIX_W-1:0]  radix_wdata,
    input  logic [WORD_BITS-1:0]         value,
    output logic                         neg,
    output logic [WORD_BITS-1:0]         mag,
    output logic [i2a_pkg::RADIX_W-1:0]  base
);

    logic [i2a_pkg::RADIX_W-1:0] radix_reg, radix_next;

    always_comb
    begin
        radix_next = radix_we ? radix_wdata : radix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= i2a_pkg::RADIX_W'(i2a_pkg::DEFAULT_RADIX);
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // bad radix falls back to base ten
    always_comb
    begin
        if (radix_reg < i2a_pkg::RADIX_W'(2) || radix_reg > i2a_pkg::RADIX_W'(MAX_RADIX))
            base = i2a_pkg::RADIX_W'(i2a_pkg::DEFAULT_RADIX);
        else
            base = radix_reg;
    end

    // most negative value wraps to its unsigned magnitude
    assign neg = value[WORD_BITS-1];
    assign mag = neg ? (~value + 1'b1) : value;

endmodule

FILE: src/i2a_back.sv
// back end: digit extraction by long division and reversed character emission
module i2a_back #(
    parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic                         q_neg,
    input  logic [WORD_BITS-1:0]         q_mag,
    input  logic [i2a_pkg::RADIX_W-1:0]  q_base,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [i2a_pkg::CHAR_W-1:0]   character,
    output logic                         last,
    output logic [i2a_pkg::LEN_W-1:0]    length
);

    localparam int STEP   = i2a_pkg::STEP_BITS;
    localparam int CHUNKS = (WORD_BITS + STEP - 1) / STEP;
    localparam int QW     = CHUNKS * STEP;
    localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W  = $clog2(WORD_BITS + 2);
    localparam int AW     = $clog2(WORD_BITS);
    localparam int RW     = i2a_pkg::RADIX_W;

    i2a_pkg::back_state_t state_reg, state_next;

    logic [QW-1:0]    quo_reg, quo_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    base_reg, base_next;
    logic             neg_reg, neg_next;
    logic [CHW-1:0]   chunk_reg, chunk_next;
    logic [CNT_W-1:0] dcount_reg, dcount_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             data_ok_reg, data_ok_next;
    logic             sign_pend_reg, sign_pend_next;

    logic                          out_valid_reg, out_valid_next;
    logic [i2a_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                          last_reg, last_next;
    logic [i2a_pkg::LEN_W-1:0]     len_reg, len_next;

    logic [6:0]       step_r;
    logic [STEP-1:0]  qbits;
    logic [QW-1:0]    quo_shift;
    logic             chunk_done;
    logic [CNT_W-1:0] dcount_inc;
    logic             digits_done;
    logic [CNT_W-1:0] rd_idx;
    logic [RW-1:0]    ram_rdata;
    logic             ram_we, ram_re;
    logic             can_load, load_digit;

    // eight restoring steps, remainder stays below the base
    always_comb
    begin
        step_r = {1'b0, rem_reg};
        qbits  = '0;
        for (int i = 0; i < STEP; i++)
        begin
            step_r = {step_r[5:0], quo_reg[QW-1-i]};
            if (step_r >= {1'b0, base_reg})
            begin
                step_r       = step_r - {1'b0, base_reg};
                qbits[STEP-1-i] = 1'b1;
            end
        end
    end

    assign quo_shift   = QW'({quo_reg, qbits});
    assign chunk_done  = (chunk_reg == CHW'(CHUNKS - 1));
    assign dcount_inc  = dcount_reg + 1'b1;
    assign digits_done = (quo_shift == '0) || (dcount_inc == CNT_W'(WORD_BITS));
    assign rd_idx      = remain_reg - 1'b1;
    assign can_load    = !out_valid_reg || pop;
    assign load_digit  = (state_reg == i2a_pkg::B_EMIT) && !sign_pend_reg && data_ok_reg
                         && can_load;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::B_IDLE:
            begin
                if (q_valid)
                    state_next = i2a_pkg::B_DIVIDE;
            end
            i2a_pkg::B_DIVIDE:
            begin
                if (chunk_done && digits_done)
                    state_next = i2a_pkg::B_EMIT;
            end
            i2a_pkg::B_EMIT:
            begin
                if (load_digit && remain_reg == '0)
                    state_next = i2a_pkg::B_IDLE;
            end
            default:
            begin
                state_next = i2a_pkg::B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        chunk_next     = chunk_reg;
        dcount_next    = dcount_reg;
        remain_next    = remain_reg;
        data_ok_next   = data_ok_reg;
        sign_pend_next = sign_pend_reg;
        out_valid_next = out_valid_reg && !pop;
        char_next      = char_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            i2a_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    quo_next    = QW'(q_mag);
                    base_next   = q_base;
                    neg_next    = q_neg;
                    rem_next    = '0;
                    chunk_next  = '0;
                    dcount_next = '0;
                end
            end
            i2a_pkg::B_DIVIDE:
            begin
                quo_next   = quo_shift;
                rem_next   = step_r[RW-1:0];
                chunk_next = chunk_reg + 1'b1;
                if (chunk_done)
                begin
                    ram_we      = 1'b1;
                    rem_next    = '0;
                    chunk_next  = '0;
                    dcount_next = dcount_inc;
                    if (digits_done)
                    begin
                        remain_next    = dcount_inc;
                        data_ok_next   = 1'b0;
                        sign_pend_next = neg_reg;
                    end
                end
            end
            i2a_pkg::B_EMIT:
            begin
                if (sign_pend_reg && can_load)
                begin
                    sign_pend_next = 1'b0;
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    len_next       = '0;
                end
                else if (load_digit)
                begin
                    data_ok_next   = 1'b0;
                    out_valid_next = 1'b1;
                    char_next      = i2a_pkg::digit_char(ram_rdata);
                    last_next      = (remain_reg == '0);
                    len_next       = (remain_reg == '0)
                                     ? i2a_pkg::LEN_W'(dcount_reg + CNT_W'(neg_reg)) : '0;
                end
                // prefetch the next digit, highest first
                if (remain_reg != '0 && (!data_ok_reg || load_digit))
                begin
                    ram_re       = 1'b1;
                    remain_next  = rd_idx;
                    data_ok_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::B_IDLE;
            chunk_reg     <= '0;
            dcount_reg    <= '0;
            remain_reg    <= '0;
            data_ok_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            dcount_reg    <= dcount_next;
            remain_reg    <= remain_next;
            data_ok_reg   <= data_ok_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
        len_reg  <= len_next;
    end

    i2a_ram #(
        .WIDTH (RW),
        .DEPTH (WORD_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dcount_reg[AW-1:0]),
        .wdata (step_r[RW-1:0]),
        .re    (ram_re),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign length    = len_reg;

    a_digit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2a_pkg::B_DIVIDE) |-> (dcount_reg < CNT_W'(WORD_BITS)))
        else $error("digit count past buffer depth");

    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2a_pkg::B_EMIT) |-> (remain_reg <= dcount_reg))
        else $error("emission index beyond digits produced");

    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2a_pkg::B_EMIT && sign_pend_reg) |-> neg_reg)
        else $error("minus pending on a non-negative number");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2a_pkg::B_DIVIDE && chunk_done && digits_done)
        |=> (sign_pend_reg == neg_reg) && (remain_reg == dcount_reg))
        else $error("emission not primed from division result");

endmodule

FILE: src/integer_to_radix_ascii.sv
// top level: signed integer to ascii text in a configurable base
//
// input side is a queue: drive value and raise push, the word is taken on a
// rising edge with push high and full low. the front classifies it (sign,
// magnitude, effective base) into a two entry queue, so up to two numbers
// can wait while the back converts the current one.
// output side is a queue too: while empty is low, character/last/length hold
// the oldest character; it is taken on an edge with pop high. characters come
// most significant first, a minus first for negatives, and last flags the
// final one, which carries the total length.
// radix is written with radix_we/radix_wdata while idle; 0, 1 and values
// above the largest base convert in base ten.
// conversion: the back pops a word from the queue, extracts its digits into
// the digit ram with the restoring divider, primes the ram for reading (a
// minus goes out here) and then emits the digits, most significant first,
// as pop takes them.
// a stalled receiver holds the output register and stops emission; the
// front keeps accepting until its queue fills.
// reset clears the radix to ten and empties both queues; no clearing pass.
module integer_to_radix_ascii #(
    parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEFAULT,
    parameter int MAX_RADIX = i2a_pkg::MAX_RADIX_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_we,
    input  logic [i2a_pkg::RADIX_W-1:0]  radix_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic [WORD_BITS-1:0]         value,
    output logic                         empty,
    input  logic                         pop,
    output logic [i2a_pkg::CHAR_W-1:0]   character,
    output logic                         last,
    output logic [i2a_pkg::LEN_W-1:0]    length
);

    localparam int RW = i2a_pkg::RADIX_W;
    localparam int QD = 1 + RW + WORD_BITS;

    // classified word from the front
    logic                 f_neg;
    logic [WORD_BITS-1:0] f_mag;
    logic [RW-1:0]        f_base;

    // queue head toward the back
    logic          q_valid, q_pop;
    logic [QD-1:0] q_rdata;

    i2a_front #(
        .WORD_BITS (WORD_BITS),
        .MAX_RADIX (MAX_RADIX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .value       (value),
        .neg         (f_neg),
        .mag         (f_mag),
        .base        (f_base)
    );

    // packed as sign, base, magnitude
    i2a_queue #(
        .WIDTH (QD)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (push),
        .wdata ({f_neg, f_base, f_mag}),
        .full  (full),
        .rd_en (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    i2a_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_neg     (q_rdata[QD-1]),
        .q_mag     (q_rdata[WORD_BITS-1:0]),
        .q_base    (q_rdata[QD-2:WORD_BITS]),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last),
        .length    (length)
    );

endmodule

FILE: test/tb_top.sv
// testbench for integer_to_radix_ascii: predicted text checked character by character
`timescale 1ns / 1ps

module tb_top;

    localparam int WORD_W      = i2a_pkg::WORD_BITS_DEFAULT;
    localparam int HOLD_CYCLES = 600;   // long receiver hold-off, fills the block
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_TAIL  = 200;   // above the slowest number (binary most negative)

    // receiver behavior between hold-offs
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_SLUGGISH
    } rx_mode_t;

    // one output word as the block presents it
    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic [i2a_pkg::LEN_W-1:0]  len;
    } char_word_t;

    // predicts the characters of every accepted number and checks them in order
    class text_checker;
        char_word_t                  expected_chars[$];
        logic [i2a_pkg::RADIX_W-1:0] radix;
        int                          errors;
        int                          numbers;
        int                          chars;

        function new();
            radix   = i2a_pkg::RADIX_W'(i2a_pkg::DEFAULT_RADIX);
            errors  = 0;
            numbers = 0;
            chars   = 0;
        endfunction

        function void write_radix(logic [i2a_pkg::RADIX_W-1:0] r);
            radix = r;
        endfunction

        // queue the text for one accepted number, most significant first
        function void take_number(logic [WORD_W-1:0] v);
            logic [WORD_W-1:0]           mag;
            logic [WORD_W-1:0]           base;
            logic [i2a_pkg::RADIX_W-1:0] digits[$];
            char_word_t                  w;
            int                          total;
            if (radix < 2 || radix > i2a_pkg::MAX_RADIX_DEFAULT)
                base = WORD_W'(i2a_pkg::DEFAULT_RADIX);
            else
                base = WORD_W'(radix);
            // unsigned magnitude, so the most negative value needs no special path
            mag = v[WORD_W-1] ? (~v + 1'b1) : v;
            do
            begin
                digits.push_front(i2a_pkg::RADIX_W'(mag % base));
                mag = mag / base;
            end
            while (mag != 0);
            total = digits.size() + (v[WORD_W-1] ? 1 : 0);
            if (v[WORD_W-1])
            begin
                w.ch   = i2a_pkg::CHAR_MINUS;
                w.last = 1'b0;
                w.len  = '0;
                expected_chars.push_back(w);
            end
            foreach (digits[i])
            begin
                if (digits[i] < 10)
                    w.ch = i2a_pkg::CHAR_ZERO + i2a_pkg::CHAR_W'(digits[i]);
                else
                    w.ch = i2a_pkg::CHAR_LOWER_A + i2a_pkg::CHAR_W'(digits[i])
                           - i2a_pkg::CHAR_W'(10);
                w.last = (i == digits.size() - 1);
                w.len  = w.last ? i2a_pkg::LEN_W'(total) : '0;
                expected_chars.push_back(w);
            end
            numbers++;
        endfunction

        function void check_char(logic [i2a_pkg::CHAR_W-1:0] ch, logic lst,
                                 logic [i2a_pkg::LEN_W-1:0] len);
            char_word_t want;
            if (expected_chars.size() == 0)
            begin
                $error("character %h (last %b, length %0d) with nothing expected", ch, lst, len);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            chars++;
            if (ch !== want.ch)
            begin
                $error("character: expected %h, got %h", want.ch, ch);
                errors++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, lst);
                errors++;
            end
            if (len !== want.len)
            begin
                $error("length: expected %0d, got %0d", want.len, len);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        radix_we;
    logic [i2a_pkg::RADIX_W-1:0] radix_wdata;
    logic                        push;
    logic                        full;
    logic [WORD_W-1:0]           value;
    logic                        empty;
    logic                        pop;
    logic [i2a_pkg::CHAR_W-1:0]  character;
    logic                        last;
    logic [i2a_pkg::LEN_W-1:0]   length;

    text_checker conv_check = new();
    bit          hold_request = 1'b0;   // asks the receiver for one long hold-off

    // directed numbers, grouped by the radix they run under
    logic [WORD_W-1:0] directed_values [24] = '{
        32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, 32'h7fff_ffff, 32'h8000_0000,
        32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
        32'd35, 32'd36, 32'hffff_ffdd, 32'd1295, 32'h7fff_ffff, 32'h8000_0000,
        32'd255, 32'hffff_ff00,
        32'd123, 32'hffff_ffd3, 32'd678, 32'h8000_0000
    };
    // the first group runs on the reset radix, the last four are out of range
    logic [i2a_pkg::RADIX_W-1:0] directed_radix [24] = '{
        6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10,
        6'd2, 6'd2, 6'd2, 6'd2, 6'd2,
        6'd36, 6'd36, 6'd36, 6'd36, 6'd36, 6'd36,
        6'd16, 6'd16,
        6'd0, 6'd1, 6'd37, 6'd63
    };
    // radix per random phase; the last phase draws its own
    logic [i2a_pkg::RADIX_W-1:0] phase_radix [8] = '{
        6'd16, 6'd2, 6'd0, 6'd36, 6'd63, 6'd7, 6'd1, 6'd37
    };

    integer_to_radix_ascii dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .push        (push),
        .full        (full),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .character   (character),
        .last        (last),
        .length      (length)
    );

    always #10 clk = ~clk;

    // offer one number and hold it until the block takes the word;
    // push stays high afterwards so a burst runs back to back
    task automatic send_value(input logic [WORD_W-1:0] v);
        push  <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        conv_check.take_number(v);
    endtask

    // radix write, only called with nothing in flight
    task automatic write_radix(input logic [i2a_pkg::RADIX_W-1:0] r);
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we <= 1'b0;
        conv_check.write_radix(r);
    endtask

    // sender pause until every predicted character has come out
    task automatic drain_text();
        while (conv_check.pending() != 0)
            @(posedge clk);
    endtask

    // mix of extremes, full-width noise, small numbers and scaled magnitudes
    function automatic logic [WORD_W-1:0] random_value();
        logic [WORD_W-1:0] v;
        case ($urandom_range(0, 7)) inside
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            [1:2]:   v = $urandom;
            [3:4]:   v = WORD_W'($urandom_range(0, 40));
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        // every drawn value, extremes and noise included, is negated half the time
        if ($urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        return v;
    endfunction

    // bursts of random length; gaps after most of them unless told to keep going
    task automatic random_phase(input int count, input bit no_gaps);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && sent < count)
            begin
                send_value(random_value());
                sent++;
                burst--;
            end
            if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(posedge clk);
            end
        end
        push <= 1'b0;
        drain_text();
    endtask

    // receiver: checks every word taken, then picks pop for the next edge.
    // the mode is redrawn whenever its random countdown runs out, and one hold-off
    // keeps pop low long enough for the front queue to fill and raise full
    initial
    begin : receiver
        int       hold_left;
        int       mode_left;
        rx_mode_t mode;
        pop       <= 1'b0;
        hold_left = 0;
        mode_left = 0;
        mode      = RX_STEADY;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                conv_check.check_char(character, last, length);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 96);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_STEADY:   pop <= 1'b1;
                    RX_CHOPPY:   pop <= ($urandom_range(0, 1) == 1);
                    default:     pop <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // stall watchdog: ends the run when no word moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int ph;
        push        <= 1'b0;
        value       <= '0;
        radix_we    <= 1'b0;
        radix_wdata <= '0;
        rst_n       <= 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: zero, one, minus one, both extremes and digit
        // boundaries per base; reset radix first, then the out-of-range ones
        for (i = 0; i < 24; i++)
        begin
            if (directed_radix[i] != conv_check.radix)
            begin
                push <= 1'b0;
                drain_text();
                write_radix(directed_radix[i]);
            end
            send_value(directed_values[i]);
        end
        push <= 1'b0;
        drain_text();

        // random part, one radix per phase, each phase drained before the next
        // write; the binary phase also carries the long receiver hold-off and
        // the base 36 phase runs with no sender gaps at all
        for (ph = 0; ph < 9; ph++)
        begin
            if (ph < 8)
                write_radix(phase_radix[ph]);
            else
                write_radix(i2a_pkg::RADIX_W'($urandom_range(0, 63)));
            if (ph == 1)
                hold_request = 1'b1;
            random_phase(10, ph == 1 || ph == 3);
        end

        // let anything unexpected show up before judging
        repeat (DRAIN_TAIL)
            @(posedge clk);
        $display("tb_top: %0d numbers converted, %0d characters compared",
                 conv_check.numbers, conv_check.chars);
        $display("tb_top: bases 2 to 36, bad radix values, one long output hold-off");
        if (conv_check.errors == 0 && conv_check.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
